// File: design/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types, codes and the CRC-16/MODBUS fold for the RTU frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

  // request codes carried in req_type
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_END  = 2'd2
  } rfr_kind_t;

  // configuration register indexes
  localparam logic CFG_GAP_TICKS   = 1'b0;
  localparam logic CFG_TRAILER_LEN = 1'b1;

  localparam logic [15:0] GAP_TICKS_RESET   = 16'd305;
  localparam logic [1:0]  TRAILER_LEN_RESET = 2'd0;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] SILENCE_MAX  = 16'hFFFF;
  localparam int          MIN_FRAME_LEN = 4;
  localparam int          CRC_HIST_DEPTH = 3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } rfr_in_t;

  typedef struct packed {
    rfr_kind_t  result_kind;
    logic [7:0] out_byte;
    logic       frame_ok;
    logic [8:0] frame_len;
    logic       overflow;
  } rfr_out_t;

  // control from the frame controller to the CRC unit
  typedef struct packed {
    logic fold;
    logic clear;
  } rfr_crc_ctrl_t;

  // fold one byte into a reflected CRC-16, one bit per step
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: design/rfr_crc_unit.sv
// ----------------------------------------------------------------------------
// rfr_crc_unit
// Running CRC-16/MODBUS with the values held before the last three bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_crc_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rfr_pkg::rfr_crc_ctrl_t ctrl,
  input  wire logic [7:0]             data,
  input  wire logic [1:0]             trailer_len,
  output logic [15:0]                 crc_part
);
  import rfr_pkg::*;

  logic [15:0] crc_accum;
  logic [15:0] crc_history [CRC_HIST_DEPTH];

  // fold a byte and shift the history, or restart on frame end
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      crc_accum <= CRC_INIT;
      for (int k = 0; k < CRC_HIST_DEPTH; k++) begin
        crc_history[k] <= CRC_INIT;
      end
    end else if (ctrl.fold) begin
      crc_accum      <= crc16_fold(crc_accum, data);
      crc_history[0] <= crc_accum;
      for (int k = 1; k < CRC_HIST_DEPTH; k++) begin
        crc_history[k] <= crc_history[k-1];
      end
    end
  end

  // pick the CRC that covers the frame without its trailer
  always_comb begin
    unique case (trailer_len)
      2'd0:    crc_part = crc_accum;
      2'd1:    crc_part = crc_history[0];
      2'd2:    crc_part = crc_history[1];
      default: crc_part = crc_history[2];
    endcase
  end

endmodule

`default_nettype wire

// File: design/rfr_frame_ctrl.sv
// ----------------------------------------------------------------------------
// rfr_frame_ctrl
// Byte counting, silence timing and frame check for one transaction a cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_frame_ctrl #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire rfr_pkg::rfr_in_t       item,
  input  wire logic [15:0]            gap_ticks,
  input  wire logic [1:0]             trailer_len,
  input  wire logic [15:0]            crc_part,
  output rfr_pkg::rfr_crc_ctrl_t      crc_ctrl,
  output rfr_pkg::rfr_out_t           result
);
  import rfr_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]   silence_count, silence_count_next;
  logic          frame_open, frame_open_next;
  logic          overflow_seen, overflow_seen_next;

  logic [15:0]   silence_inc;
  logic [CW:0]   payload_len;
  logic [CW+8:0] count_ext;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      silence_count <= '0;
      frame_open    <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      byte_count    <= byte_count_next;
      silence_count <= silence_count_next;
      frame_open    <= frame_open_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  assign silence_inc = (silence_count == SILENCE_MAX) ? silence_count
                                                      : silence_count + 16'd1;
  assign payload_len = {1'b0, byte_count} - {{(CW - 1){1'b0}}, trailer_len};
  assign count_ext   = {9'd0, byte_count};

  // next state and result for the transaction in hand
  always_comb begin
    byte_count_next    = byte_count;
    silence_count_next = silence_count;
    frame_open_next    = frame_open;
    overflow_seen_next = overflow_seen;
    crc_ctrl           = '0;
    result             = '0;
    result.result_kind = KIND_NONE;

    if (item.req_type == REQ_BYTE) begin
      frame_open_next    = 1'b1;
      silence_count_next = '0;
      if ({1'b0, byte_count} >= (CW + 1)'(MAX_FRAME)) begin
        // drop the byte and flag the frame
        overflow_seen_next = 1'b1;
      end else begin
        crc_ctrl.fold      = step;
        byte_count_next    = byte_count + CW'(1);
        result.result_kind = KIND_BYTE;
        result.out_byte    = item.rx_byte;
      end
    end else if (frame_open) begin
      silence_count_next = silence_inc;
      if (silence_inc > gap_ticks) begin
        // end the frame and report it
        result.result_kind = KIND_END;
        result.frame_ok    = !payload_len[CW] &&
                             (payload_len[CW-1:0] >= CW'(MIN_FRAME_LEN)) &&
                             (crc_part == 16'd0) && !overflow_seen;
        result.frame_len   = count_ext[8:0];
        result.overflow    = overflow_seen;
        crc_ctrl.clear     = step;
        byte_count_next    = '0;
        silence_count_next = '0;
        frame_open_next    = 1'b0;
        overflow_seen_next = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/rtu_frame_receiver_crc_check.sv
// A transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle unless the result stalls; the CRC fold of
// one byte is a single table-free 8-step bit loop from input to CRC register.
// Reset (synchronous, rst high): pipeline empty, CRC 0xFFFF, counters zero,
// no frame open, gap_ticks 305, trailer_len 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
// rtu_frame_receiver_crc_check
// Modbus RTU frame receiver with CRC-16/MODBUS check and silence timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module rtu_frame_receiver_crc_check #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire rfr_pkg::rfr_in_t  req,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output rfr_pkg::rfr_out_t      res,
  input  wire logic              cfg_we,
  input  wire logic              cfg_addr,
  input  wire logic [15:0]       cfg_data
);
  import rfr_pkg::*;

  logic          s1_valid;
  rfr_in_t       s1_data;
  logic          res_load;
  logic          s1_advance;
  logic [15:0]   gap_ticks;
  logic [1:0]    trailer_len;
  logic [15:0]   crc_part;
  rfr_crc_ctrl_t crc_ctrl;
  rfr_out_t      result;

  assign res_load   = !res_valid || res_ready;
  assign s1_advance = s1_valid && res_load;
  assign req_ready  = !s1_valid || res_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks   <= GAP_TICKS_RESET;
      trailer_len <= TRAILER_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GAP_TICKS:   gap_ticks   <= cfg_data;
        CFG_TRAILER_LEN: trailer_len <= cfg_data[1:0];
        default:         ;
      endcase
    end
  end

  // input register: take a transaction whenever the stage can move on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_data <= req;
    end
  end

  rfr_crc_unit u_crc (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (crc_ctrl),
    .data        (s1_data.rx_byte),
    .trailer_len (trailer_len),
    .crc_part    (crc_part)
  );

  rfr_frame_ctrl #(
    .MAX_FRAME (MAX_FRAME)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_advance),
    .item        (s1_data),
    .gap_ticks   (gap_ticks),
    .trailer_len (trailer_len),
    .crc_part    (crc_part),
    .crc_ctrl    (crc_ctrl),
    .result      (result)
  );

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res <= result;
    end
  end

  // a good frame never carries overflow and has room for address, code and CRC
  a_good_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.result_kind == KIND_END) && res.frame_ok
      |-> !res.overflow && (res.frame_len >= 9'd4))
    else $error("good frame with overflow or short length");

  // a non-byte result always has a zero data byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.result_kind != KIND_BYTE) |-> (res.out_byte == 8'd0))
    else $error("data byte set on a non-byte result");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid && !res_ready && s1_valid)
    else $error("input stalled without output backpressure");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && req_ready)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: tb/rfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_frame_checker
// Watches the request, result and register ports of the RTU frame receiver.
// Keeps its own copy of the frame state (running CRC-16/MODBUS, CRC history,
// byte and silence counts), predicts one result per accepted request and
// compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------

module rfr_frame_checker #(
  parameter int MAX_FRAME = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  rfr_pkg::rfr_in_t  req,
  input  logic              res_valid,
  input  logic              res_ready,
  input  rfr_pkg::rfr_out_t res,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [15:0]       cfg_data,
  output int                fail_count,
  output int                results_due
);
  import rfr_pkg::*;

  // register copies
  logic [15:0] gap_limit;
  logic [1:0]  trailer_bytes;

  // frame state
  logic [15:0] crc_run;
  logic [15:0] crc_prior [0:2];
  int          stored_bytes;
  logic [15:0] silent_ticks;
  logic        frame_live;
  logic        dropped_bytes;

  rfr_out_t    frame_results[$];
  int          errors;

  // fold one byte into the reflected CRC-16 (poly 0xA001)
  function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
    logic [15:0] r;
    r = crc ^ {8'h00, data};
    repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic void drop_frame();
    crc_run       = 16'hFFFF;
    crc_prior[0]  = 16'hFFFF;
    crc_prior[1]  = 16'hFFFF;
    crc_prior[2]  = 16'hFFFF;
    stored_bytes  = 0;
    silent_ticks  = 16'd0;
    frame_live    = 1'b0;
    dropped_bytes = 1'b0;
  endfunction

  // advance the frame state by one transaction and return its result
  function automatic rfr_out_t receive_step(input rfr_in_t item);
    rfr_out_t    o;
    logic [15:0] check_crc;
    int          body_len;
    o = '0;
    o.result_kind = KIND_NONE;
    if (item.req_type == REQ_BYTE) begin
      frame_live   = 1'b1;
      silent_ticks = 16'd0;
      if (stored_bytes >= MAX_FRAME) begin
        dropped_bytes = 1'b1;
      end else begin
        crc_prior[2]  = crc_prior[1];
        crc_prior[1]  = crc_prior[0];
        crc_prior[0]  = crc_run;
        crc_run       = crc_fold_byte(crc_run, item.rx_byte);
        stored_bytes  = stored_bytes + 1;
        o.result_kind = KIND_BYTE;
        o.out_byte    = item.rx_byte;
      end
    end else if (frame_live) begin
      // hold the silence count at its ceiling
      if (silent_ticks != 16'hFFFF) silent_ticks = silent_ticks + 16'd1;
      if (silent_ticks > gap_limit) begin
        check_crc = (trailer_bytes == 2'd0) ? crc_run : crc_prior[trailer_bytes - 2'd1];
        body_len  = stored_bytes - int'(trailer_bytes);
        o.result_kind = KIND_END;
        o.frame_ok    = (body_len >= 4) && (check_crc == 16'h0000) && !dropped_bytes;
        o.frame_len   = stored_bytes[8:0];
        o.overflow    = dropped_bytes;
        drop_frame();
      end
    end
    return o;
  endfunction

  function automatic void check_result(input rfr_out_t got);
    rfr_out_t want;
    if (frame_results.size() == 0) begin
      $error("unexpected result: result_kind %0d", got.result_kind);
      errors = errors + 1;
    end else begin
      want = frame_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors = errors + 1;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        errors = errors + 1;
      end
      if (got.frame_ok !== want.frame_ok) begin
        $error("frame_ok: expected %0d, got %0d", want.frame_ok, got.frame_ok);
        errors = errors + 1;
      end
      if (got.frame_len !== want.frame_len) begin
        $error("frame_len: expected %0d, got %0d", want.frame_len, got.frame_len);
        errors = errors + 1;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        errors = errors + 1;
      end
    end
  endfunction

  // sample all ports at the edge; predict before popping so a fast block still lines up
  always @(posedge clk) begin
    if (rst) begin
      gap_limit     = 16'd305;
      trailer_bytes = 2'd0;
      drop_frame();
      frame_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_GAP_TICKS) gap_limit = cfg_data;
        else trailer_bytes = cfg_data[1:0];
      end
      if (req_valid && req_ready) frame_results.push_back(receive_step(req));
      if (res_valid && res_ready) check_result(res);
    end
    fail_count  <= errors;
    results_due <= frame_results.size();
  end

endmodule

// File: tb/tb_rtu_frame_receiver_crc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtu_frame_receiver_crc_check
// Feeds the RTU frame receiver with directed frames (minimum length, trailer
// handling, short frames) and then random phases of good, corrupted and
// random frames under changing gap and trailer settings, with random idling
// on both channels.
// ----------------------------------------------------------------------------

module tb_rtu_frame_receiver_crc_check;
  import rfr_pkg::*;

  localparam int MAX_FRAME      = 256;
  localparam int ITEM_TARGET    = 1320;
  localparam int IDLE_MAX       = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  rfr_in_t     req;
  logic        res_valid;
  logic        res_ready = 1'b0;
  rfr_out_t    res;
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_data;

  int          mismatch_count;
  int          results_due;

  // stimulus state
  int          idle_max = IDLE_MAX;
  int          sent_items;
  int          cur_gap;
  int          cur_trailer;
  bit          allow_pause;
  logic [7:0]  frame_buf [0:MAX_FRAME + 8];
  int          fill_n;
  int          ready_hold;
  int          ready_draw;
  int          quiet_cycles;

  rtu_frame_receiver_crc_check #(
    .MAX_FRAME(MAX_FRAME)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  rfr_frame_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (mismatch_count),
    .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: stall a random number of cycles after each transaction
  always @(posedge clk) begin
    if (rst) begin
      res_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (res_ready && res_valid) begin
      ready_draw = $urandom_range(0, idle_max);
      ready_hold <= ready_draw;
      res_ready  <= (ready_draw == 0);
    end else if (!res_ready) begin
      if (ready_hold <= 1) res_ready <= 1'b1;
      if (ready_hold > 0) ready_hold <= ready_hold - 1;
    end
  end

  // abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (req_valid && req_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rtu_frame_receiver_crc_check NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays up across back-to-back transactions; drop it only for an idle gap
  task automatic push_item(input logic kind, input logic [7:0] data);
    rfr_in_t item;
    int      wait_n;
    wait_n = $urandom_range(0, idle_max);
    if (wait_n > 0) begin
      req_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    item.req_type = kind;
    item.rx_byte  = data;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_items = sent_items + 1;
  endtask

  task automatic send_byte(input logic [7:0] data);
    push_item(REQ_BYTE, data);
  endtask

  task automatic send_tick();
    push_item(REQ_TICK, 8'($urandom));
  endtask

  // drain all results, then write one register
  task automatic write_reg(input logic addr, input logic [15:0] value);
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_gap(input int value);
    cur_gap = value;
    write_reg(CFG_GAP_TICKS, 16'(value));
  endtask

  task automatic set_trailer(input int value);
    cur_trailer = value;
    write_reg(CFG_TRAILER_LEN, 16'(value));
  endtask

  task automatic put_byte(input logic [7:0] data);
    frame_buf[fill_n] = data;
    fill_n = fill_n + 1;
  endtask

  // append the CRC of the bytes so far, low byte first
  task automatic add_crc();
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < fill_n; i++) begin
      c = c ^ {8'h00, frame_buf[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    put_byte(c[7:0]);
    put_byte(c[15:8]);
  endtask

  // send the buffered frame, maybe with short pauses inside, then close it
  task automatic emit_frame();
    for (int i = 0; i < fill_n; i++) begin
      send_byte(frame_buf[i]);
      if (allow_pause && (i + 1 < fill_n) && (cur_gap > 0) && ($urandom_range(0, 9) == 0))
        repeat ($urandom_range(1, cur_gap)) send_tick();
    end
    repeat (cur_gap + 1) send_tick();
    fill_n = 0;
  endtask

  task automatic random_frame(input bit full_size, input bit overrun);
    int sel;
    int body;
    int tail;
    int idx;
    sel = $urandom_range(0, 99);
    if (overrun) begin
      repeat (MAX_FRAME + $urandom_range(1, 4)) put_byte(8'($urandom));
    end else if (full_size || sel < 65) begin
      body = full_size ? MAX_FRAME - 2 - cur_trailer : $urandom_range(0, 10);
      tail = (full_size || $urandom_range(0, 3) != 0) ? cur_trailer : $urandom_range(0, 3);
      repeat (body) put_byte(8'($urandom));
      add_crc();
      repeat (tail) put_byte(($urandom_range(0, 9) < 7) ? 8'hFF : 8'($urandom));
      // flip one bit now and then
      if (!full_size && $urandom_range(0, 6) == 0) begin
        idx = $urandom_range(0, fill_n - 1);
        frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
    end
    emit_frame();
  endtask

  initial begin
    bit full_done;
    bit overrun_done;
    int pick;
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    req         <= '0;
    cfg_we      <= 1'b0;
    cfg_addr    <= CFG_GAP_TICKS;
    cfg_data    <= 16'd0;
    sent_items   = 0;
    fill_n       = 0;
    cur_gap      = 305;
    cur_trailer  = 0;
    allow_pause  = 1'b0;
    full_done    = 1'b0;
    overrun_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // tick while no frame is open
    send_tick();

    // minimum good frame with byte extremes; first tick sits at the gap and must not end it
    set_gap(1);
    set_trailer(0);
    put_byte(8'h00);
    put_byte(8'hFF);
    add_crc();
    emit_frame();

    // good frame behind an FF FF FF trailer; gap zero closes on the first tick
    set_gap(0);
    set_trailer(3);
    put_byte(8'h12);
    put_byte(8'h34);
    put_byte(8'h56);
    add_crc();
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_byte(8'hFF);
    emit_frame();

    // trailer longer than the frame
    put_byte(8'hAB);
    put_byte(8'hCD);
    emit_frame();

    // zero residue but too short
    set_trailer(0);
    put_byte(8'h5A);
    add_crc();
    emit_frame();

    // random phases
    allow_pause = 1'b1;
    while (sent_items < ITEM_TARGET) begin
      idle_max = ($urandom_range(0, 6) == 0) ? 0 : IDLE_MAX;
      pick = $urandom_range(0, 9);
      case (pick)
        0:             set_gap(0);
        1, 2, 3, 4, 5: set_gap($urandom_range(1, 4));
        6, 7, 8:       set_gap($urandom_range(5, 24));
        default:       set_gap($urandom_range(25, 80));
      endcase
      set_trailer($urandom_range(0, 3));
      repeat ($urandom_range(3, 8)) begin
        if (!full_done && sent_items > 300) begin
          full_done = 1'b1;
          random_frame(1'b1, 1'b0);
        end else if (!overrun_done && sent_items > 700) begin
          overrun_done = 1'b1;
          random_frame(1'b0, 1'b1);
        end else begin
          random_frame(1'b0, 1'b0);
        end
        // stray ticks between frames
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_tick();
      end
    end

    // drain and let any stray result show up
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_rtu_frame_receiver_crc_check OK");
    end else begin
      $display("tb_rtu_frame_receiver_crc_check NOT OK");
    end
    $finish;
  end

endmodule
